// File: sv/srbm_pkg.sv
// Package for the snapshot reference-count block manager.
// Holds the sizes, codes, payload structs and controller/datapath interface types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package srbm_pkg;

    // Store sizes
    localparam int MAX_BLOCKS    = 64;
    localparam int MAX_SNAPSHOTS = 8;
    localparam int MAX_LIST      = 16;

    // Derived widths
    localparam int REF_W   = 4;
    localparam int BLK_W   = $clog2(MAX_BLOCKS);
    localparam int SNAP_W  = $clog2(MAX_SNAPSHOTS);
    localparam int LIST_W  = $clog2(MAX_LIST);
    localparam int LEN_W   = $clog2(MAX_LIST + 1);
    localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
    localparam int SNL_AW  = SNAP_W + LIST_W;
    localparam int VER_W   = 16;
    localparam int PCT_W   = 7;
    localparam int FREED_W = 5;
    localparam int PCT_FULL = 100;
    localparam int NUM_W   = $clog2(MAX_LIST * PCT_FULL + 1);
    localparam int META_W  = VER_W + LEN_W;

    localparam logic [REF_W-1:0] REF_TOP = 4'd15;

    typedef enum logic [1:0] {
        KIND_APPEND  = 2'd0,
        KIND_CREATE  = 2'd1,
        KIND_RESTORE = 2'd2,
        KIND_DELETE  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_FOUND  = 3'd1,
        ST_BLOCK_FULL = 3'd2,
        ST_LIST_FULL  = 3'd3,
        ST_SNAP_FULL  = 3'd4
    } status_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] version;
    } cmd_t;

    typedef struct packed {
        status_t     status;
        logic [5:0]  blk_slot;
        logic [15:0] new_version;
        logic [6:0]  progress_pct;
        logic [4:0]  freed_count;
        logic        last;
    } rsp_t;

    // Reference-count update applied by the datapath
    typedef enum logic [1:0] {
        RO_NONE,
        RO_ONE,
        RO_INC,
        RO_DEC
    } ref_op_t;

    // Which result the datapath builds
    typedef enum logic [2:0] {
        EM_NONE,
        EM_ERR,
        EM_APPEND,
        EM_CREATE,
        EM_DELETE,
        EM_RESTORE,
        EM_EMPTY
    } em_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_A_SCAN,
        S_A_WR,
        S_C_SCAN,
        S_C_LOOP,
        S_C_RD1,
        S_C_RD2,
        S_C_FIN,
        S_F_RD,
        S_F_CK,
        S_DEC_LOOP,
        S_DEC_RD1,
        S_DEC_RD2,
        S_DEL_FIN,
        S_R_START,
        S_R_LOOP,
        S_R_RD1,
        S_R_RD2,
        S_R_DIV
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic    latch;
        logic    cnt_clr;
        logic    cnt_inc;
        logic    cur_rd;
        logic    snl_rd;
        logic    meta_rd;
        logic    ref_rd;
        logic    ref_src_snl;
        ref_op_t ref_op;
        logic    cur_wr_app;
        logic    cur_wr_copy;
        logic    snl_wr_copy;
        logic    snap_ld;
        logic    n_ld;
        logic    meta_wr;
        logic    valid_clr;
        logic    len_from_n;
        logic    div_start;
        em_t     emit;
        status_t err;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        kind_t kind;
        logic  len_full;
        logic  nz_cnt;
        logic  valid_cnt;
        logic  cnt_eq_len;
        logic  cnt_eq_n;
        logic  cnt_last_blk;
        logic  cnt_last_snap;
        logic  cnt_eq_ms;
        logic  match;
        logic  n_zero;
        logic  div_done;
        logic  last_item;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: sv/srbm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module srbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: sv/srbm_div.sv
// Restoring divider for restore progress: one quotient bit per cycle.
// Depends on srbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srbm_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [srbm_pkg::NUM_W-1:0] num,
    input  wire logic [srbm_pkg::LEN_W-1:0] den,
    output logic                            done,
    output logic      [srbm_pkg::PCT_W-1:0] quot
);

    import srbm_pkg::*;

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [LEN_W-1:0]  den_reg, den_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [LEN_W:0]    trial;
    logic              fits;

    // One shift-subtract step
    always_comb
    begin
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        fits      = (trial >= {1'b0, den_reg});
        run_next  = run_reg;
        done_next = done_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            run_next  = 1'b1;
            done_next = 1'b0;
            step_next = '0;
            rem_next  = '0;
            den_next  = den;
            quo_next  = num;
        end
        else if (run_reg)
        begin
            rem_next  = fits ? LEN_W'(trial - {1'b0, den_reg}) : trial[LEN_W-1:0];
            quo_next  = {quo_reg[NUM_W-2:0], fits};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(NUM_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Operands
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quot = quo_reg[PCT_W-1:0];

endmodule

`default_nettype wire

// File: sv/srbm_ctrl.sv
// Command sequencer for the block manager: walks scans, list copies and count updates.
// Depends on srbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srbm_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire srbm_pkg::dp_stat_t stat,
    output srbm_pkg::dp_cmd_t       cmd
);

    import srbm_pkg::*;

    state_t state_reg, state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (start) state_next = S_DISPATCH;
            S_DISPATCH:
                unique case (stat.kind)
                    KIND_APPEND:  state_next = stat.len_full ? S_IDLE : S_A_SCAN;
                    KIND_CREATE:  state_next = S_C_SCAN;
                    default:      state_next = S_F_RD;
                endcase
            S_A_SCAN:
                if (!stat.nz_cnt)          state_next = S_A_WR;
                else if (stat.cnt_last_blk) state_next = S_IDLE;
            S_A_WR:
                state_next = S_IDLE;
            S_C_SCAN:
                if (!stat.valid_cnt)         state_next = S_C_LOOP;
                else if (stat.cnt_last_snap) state_next = S_IDLE;
            S_C_LOOP:
                state_next = stat.cnt_eq_len ? S_C_FIN : S_C_RD1;
            S_C_RD1:
                state_next = S_C_RD2;
            S_C_RD2:
                state_next = S_C_LOOP;
            S_C_FIN:
                state_next = S_IDLE;
            S_F_RD:
                state_next = stat.cnt_eq_ms ? S_IDLE : S_F_CK;
            S_F_CK:
                state_next = stat.match ? S_DEC_LOOP : S_F_RD;
            S_DEC_LOOP:
                if (stat.kind == KIND_DELETE)
                    state_next = stat.cnt_eq_n ? S_DEL_FIN : S_DEC_RD1;
                else
                    state_next = stat.cnt_eq_len ? S_R_START : S_DEC_RD1;
            S_DEC_RD1:
                state_next = S_DEC_RD2;
            S_DEC_RD2:
                state_next = S_DEC_LOOP;
            S_DEL_FIN:
                state_next = S_IDLE;
            S_R_START:
                state_next = stat.n_zero ? S_IDLE : S_R_LOOP;
            S_R_LOOP:
                state_next = S_R_RD1;
            S_R_RD1:
                state_next = S_R_RD2;
            S_R_RD2:
                state_next = S_R_DIV;
            S_R_DIV:
                if (stat.div_done) state_next = stat.last_item ? S_IDLE : S_R_LOOP;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        cmd.emit = EM_NONE;
        cmd.err  = ST_OK;
        busy     = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
                if (start)
                begin
                    cmd.latch   = 1'b1;
                    cmd.cnt_clr = 1'b1;
                end
            S_DISPATCH:
                if (stat.kind == KIND_APPEND && stat.len_full)
                begin
                    cmd.emit = EM_ERR;
                    cmd.err  = ST_LIST_FULL;
                end
            S_A_SCAN:
                if (stat.nz_cnt)
                begin
                    if (stat.cnt_last_blk)
                    begin
                        cmd.emit = EM_ERR;
                        cmd.err  = ST_BLOCK_FULL;
                    end
                    else
                    begin
                        cmd.cnt_inc = 1'b1;
                    end
                end
            S_A_WR:
            begin
                cmd.ref_op     = RO_ONE;
                cmd.cur_wr_app = 1'b1;
                cmd.emit       = EM_APPEND;
            end
            S_C_SCAN:
                if (!stat.valid_cnt)
                begin
                    cmd.snap_ld = 1'b1;
                    cmd.cnt_clr = 1'b1;
                end
                else if (stat.cnt_last_snap)
                begin
                    cmd.emit = EM_ERR;
                    cmd.err  = ST_SNAP_FULL;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                end
            S_C_LOOP:
                cmd.cur_rd = !stat.cnt_eq_len;
            S_C_RD1:
            begin
                cmd.snl_wr_copy = 1'b1;
                cmd.ref_rd      = 1'b1;
            end
            S_C_RD2:
            begin
                cmd.ref_op  = RO_INC;
                cmd.cnt_inc = 1'b1;
            end
            S_C_FIN:
            begin
                cmd.meta_wr = 1'b1;
                cmd.emit    = EM_CREATE;
            end
            S_F_RD:
                if (stat.cnt_eq_ms)
                begin
                    cmd.emit = EM_ERR;
                    cmd.err  = ST_NOT_FOUND;
                end
                else
                begin
                    cmd.meta_rd = 1'b1;
                end
            S_F_CK:
                if (stat.match)
                begin
                    cmd.snap_ld = 1'b1;
                    cmd.n_ld    = 1'b1;
                    cmd.cnt_clr = 1'b1;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                end
            S_DEC_LOOP:
                if (stat.kind == KIND_DELETE)
                begin
                    cmd.snl_rd = !stat.cnt_eq_n;
                end
                else if (stat.cnt_eq_len)
                begin
                    cmd.len_from_n = 1'b1;
                    cmd.cnt_clr    = 1'b1;
                end
                else
                begin
                    cmd.cur_rd = 1'b1;
                end
            S_DEC_RD1:
            begin
                cmd.ref_rd      = 1'b1;
                cmd.ref_src_snl = (stat.kind == KIND_DELETE);
            end
            S_DEC_RD2:
            begin
                cmd.ref_op  = RO_DEC;
                cmd.cnt_inc = 1'b1;
            end
            S_DEL_FIN:
            begin
                cmd.valid_clr = 1'b1;
                cmd.emit      = EM_DELETE;
            end
            S_R_START:
                if (stat.n_zero) cmd.emit = EM_EMPTY;
            S_R_LOOP:
                cmd.snl_rd = 1'b1;
            S_R_RD1:
            begin
                cmd.cur_wr_copy = 1'b1;
                cmd.ref_rd      = 1'b1;
                cmd.ref_src_snl = 1'b1;
                cmd.div_start   = 1'b1;
            end
            S_R_RD2:
                cmd.ref_op = RO_INC;
            S_R_DIV:
                if (stat.div_done)
                begin
                    cmd.emit    = EM_RESTORE;
                    cmd.cnt_inc = 1'b1;
                end
            default:
            begin
                cmd.emit = EM_NONE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/srbm_dp.sv
// Datapath of the block manager: count, list and snapshot stores, counters, result register.
// Depends on srbm_pkg, srbm_ram and srbm_div.
`timescale 1ns / 1ps
`default_nettype none

module srbm_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire srbm_pkg::cmd_t    cmd_in,
    input  wire srbm_pkg::dp_cmd_t cmd,
    output srbm_pkg::dp_stat_t     stat,
    output logic                   rsp_valid,
    output srbm_pkg::rsp_t         rsp
);

    import srbm_pkg::*;

    // Command latch and loop state
    kind_t                kind_reg;
    logic [VER_W-1:0]     ver_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [SNAP_W-1:0]    snap_reg;
    logic [BLK_W-1:0]     blk_reg;
    logic [LEN_W-1:0]     n_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [FREED_W-1:0]   freed_reg;
    logic [VER_W-1:0]     ver_cnt_reg;
    logic [MAX_BLOCKS-1:0]    nz_reg;
    logic [MAX_SNAPSHOTS-1:0] valid_reg;
    logic                 rsp_valid_reg;
    rsp_t                 rsp_reg;
    rsp_t                 rsp_next;

    // RAM ports
    logic                 ref_we;
    logic [BLK_W-1:0]     ref_waddr;
    logic [REF_W-1:0]     ref_wdata;
    logic [BLK_W-1:0]     ref_raddr;
    logic [REF_W-1:0]     ref_q;
    logic                 cur_we;
    logic [LIST_W-1:0]    cur_waddr;
    logic [BLK_W-1:0]     cur_wdata;
    logic [BLK_W-1:0]     cur_q;
    logic [SNL_AW-1:0]    snl_addr;
    logic [BLK_W-1:0]     snl_q;
    logic [META_W-1:0]    meta_q;

    logic [REF_W-1:0]     ref_cur;
    logic                 div_done;
    logic [PCT_W-1:0]     div_quot;
    logic [NUM_W-1:0]     div_num;
    logic                 last_item;

    // Count store: an entry whose flag is clear reads as zero
    srbm_ram #(.WIDTH(REF_W), .DEPTH(MAX_BLOCKS)) u_ref_ram (
        .clk     (clk),
        .wr_en   (ref_we),
        .wr_addr (ref_waddr),
        .wr_data (ref_wdata),
        .rd_en   (cmd.ref_rd),
        .rd_addr (ref_raddr),
        .rd_data (ref_q)
    );

    srbm_ram #(.WIDTH(BLK_W), .DEPTH(MAX_LIST)) u_cur_ram (
        .clk     (clk),
        .wr_en   (cur_we),
        .wr_addr (cur_waddr),
        .wr_data (cur_wdata),
        .rd_en   (cmd.cur_rd),
        .rd_addr (cnt_reg[LIST_W-1:0]),
        .rd_data (cur_q)
    );

    srbm_ram #(.WIDTH(BLK_W), .DEPTH(MAX_SNAPSHOTS * MAX_LIST)) u_snl_ram (
        .clk     (clk),
        .wr_en   (cmd.snl_wr_copy),
        .wr_addr (snl_addr),
        .wr_data (cur_q),
        .rd_en   (cmd.snl_rd),
        .rd_addr (snl_addr),
        .rd_data (snl_q)
    );

    srbm_ram #(.WIDTH(META_W), .DEPTH(MAX_SNAPSHOTS)) u_meta_ram (
        .clk     (clk),
        .wr_en   (cmd.meta_wr),
        .wr_addr (snap_reg),
        .wr_data ({ver_cnt_reg, len_reg}),
        .rd_en   (cmd.meta_rd),
        .rd_addr (cnt_reg[SNAP_W-1:0]),
        .rd_data (meta_q)
    );

    assign div_num = NUM_W'((32'(cnt_reg) + 32'd1) * 32'(PCT_FULL));

    srbm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (n_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Store addressing and count update
    always_comb
    begin
        snl_addr  = {snap_reg, cnt_reg[LIST_W-1:0]};
        ref_raddr = cmd.ref_src_snl ? snl_q : cur_q;
        ref_cur   = nz_reg[blk_reg] ? ref_q : '0;
        ref_we    = 1'b0;
        ref_waddr = blk_reg;
        ref_wdata = ref_cur;
        case (cmd.ref_op)
            RO_ONE:
            begin
                ref_we    = 1'b1;
                ref_waddr = cnt_reg[BLK_W-1:0];
                ref_wdata = REF_W'(1);
            end
            RO_INC:
            begin
                ref_we    = 1'b1;
                ref_wdata = (ref_cur < REF_TOP) ? ref_cur + REF_W'(1) : ref_cur;
            end
            RO_DEC:
            begin
                ref_we    = (ref_cur != '0);
                ref_wdata = ref_cur - REF_W'(1);
            end
            default:
            begin
                ref_we = 1'b0;
            end
        endcase
        cur_we    = cmd.cur_wr_app || cmd.cur_wr_copy;
        cur_waddr = cmd.cur_wr_app ? len_reg[LIST_W-1:0] : cnt_reg[LIST_W-1:0];
        cur_wdata = cmd.cur_wr_app ? cnt_reg[BLK_W-1:0] : snl_q;
    end

    assign last_item = ((cnt_reg + CNT_W'(1)) == CNT_W'(n_reg));

    // Status to the controller
    always_comb
    begin
        stat.kind          = kind_reg;
        stat.len_full      = (len_reg >= LEN_W'(MAX_LIST));
        stat.nz_cnt        = nz_reg[cnt_reg[BLK_W-1:0]];
        stat.valid_cnt     = valid_reg[cnt_reg[SNAP_W-1:0]];
        stat.cnt_eq_len    = (cnt_reg == CNT_W'(len_reg));
        stat.cnt_eq_n      = (cnt_reg == CNT_W'(n_reg));
        stat.cnt_last_blk  = (cnt_reg == CNT_W'(MAX_BLOCKS - 1));
        stat.cnt_last_snap = (cnt_reg == CNT_W'(MAX_SNAPSHOTS - 1));
        stat.cnt_eq_ms     = (cnt_reg == CNT_W'(MAX_SNAPSHOTS));
        stat.match         = valid_reg[cnt_reg[SNAP_W-1:0]]
                             && (meta_q[META_W-1:LEN_W] == ver_reg);
        stat.n_zero        = (n_reg == '0);
        stat.div_done      = div_done;
        stat.last_item     = last_item;
    end

    // Result formatting
    always_comb
    begin
        rsp_next      = '0;
        rsp_next.last = 1'b1;
        case (cmd.emit)
            EM_ERR:
                rsp_next.status = cmd.err;
            EM_APPEND:
                rsp_next.blk_slot = 6'(cnt_reg[BLK_W-1:0]);
            EM_CREATE:
                rsp_next.new_version = ver_cnt_reg;
            EM_DELETE:
                rsp_next.freed_count = freed_reg;
            EM_EMPTY:
            begin
                rsp_next.progress_pct = PCT_W'(PCT_FULL);
                rsp_next.freed_count  = freed_reg;
            end
            EM_RESTORE:
            begin
                rsp_next.blk_slot     = 6'(blk_reg);
                rsp_next.progress_pct = div_quot;
                rsp_next.freed_count  = last_item ? freed_reg : '0;
                rsp_next.last         = last_item;
            end
            default:
                rsp_next.status = ST_OK;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            nz_reg        <= '0;
            valid_reg     <= '0;
            ver_cnt_reg   <= VER_W'(1);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= (cmd.emit != EM_NONE);
            if (cmd.cur_wr_app)
                len_reg <= len_reg + LEN_W'(1);
            else if (cmd.len_from_n)
                len_reg <= n_reg;
            if (ref_we)
                nz_reg[ref_waddr] <= (ref_wdata != '0);
            if (cmd.meta_wr)
            begin
                valid_reg[snap_reg] <= 1'b1;
                ver_cnt_reg <= (ver_cnt_reg == '1) ? VER_W'(1) : ver_cnt_reg + VER_W'(1);
            end
            else if (cmd.valid_clr)
            begin
                valid_reg[snap_reg] <= 1'b0;
            end
        end
    end

    // Loop registers and result register
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            kind_reg  <= cmd_in.kind;
            ver_reg   <= cmd_in.version;
            freed_reg <= '0;
        end
        else if (cmd.ref_op == RO_DEC && ref_cur == REF_W'(1))
        begin
            freed_reg <= freed_reg + FREED_W'(1);
        end
        if (cmd.cnt_clr)
            cnt_reg <= '0;
        else if (cmd.cnt_inc)
            cnt_reg <= cnt_reg + CNT_W'(1);
        if (cmd.snap_ld)
            snap_reg <= cnt_reg[SNAP_W-1:0];
        if (cmd.n_ld)
            n_reg <= meta_q[LEN_W-1:0];
        if (cmd.ref_rd)
            blk_reg <= ref_raddr;
        if (cmd.emit != EM_NONE)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Error results are always single and final
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.status != ST_OK |-> rsp_reg.last && rsp_reg.blk_slot == '0)
        else $error("error result not final");

    // Only a restore produces more than one result
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && kind_reg != KIND_RESTORE |-> rsp_reg.last)
        else $error("multi-result from non-restore");

    // Current length never exceeds the list size
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |-> len_reg <= LEN_W'(MAX_LIST))
        else $error("current list overflow");

    // Version counter never reaches zero
    a_ver: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.meta_wr |=> ver_cnt_reg != '0)
        else $error("version counter hit zero");

endmodule

`default_nettype wire

// File: sv/snapshot_refcount_block_manager.sv
// Top level of the copy-on-write snapshot block manager with reference counts.
// Depends on srbm_pkg, srbm_ctrl and srbm_dp.
//
//   channel   | signals                  | transfer
//   ----------+--------------------------+--------------------------------
//   command   | start, busy, cmd         | edge with start high, busy low
//   result    | rsp_valid, rsp           | every cycle rsp_valid is high
//
// Append: scans the count slots (up to 64), then writes one list entry.
// Create: scans the snapshot slots (up to 8), then copies each list entry.
// Restore/delete: search the snapshot slots, then release each entry;
//   restore then copies back each block, waiting on the progress divider.
// Reset clears the count flags, snapshot flags and list length; no clearing pass.
// Results leave a register in the cycle after they are formed; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module snapshot_refcount_block_manager (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire srbm_pkg::cmd_t cmd,
    output logic                rsp_valid,
    output srbm_pkg::rsp_t      rsp
);

    import srbm_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    // Sequencer
    srbm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (dp_stat),
        .cmd   (dp_cmd)
    );

    // Stores and arithmetic
    srbm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_in    (cmd),
        .cmd       (dp_cmd),
        .stat      (dp_stat),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
